// ===== src/ascp_pkg.sv =====
// Shared types, character codes and the fraction weight table for the
// ASCII setpoint command parser. No dependencies.
package ascp_pkg;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChS       = 8'h53;
  localparam logic [7:0] ChR       = 8'h52;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChPoint   = 8'h2E;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosColon  = 2'd2;
  localparam logic [1:0] PosNumber = 2'd3;

  localparam int unsigned SteerW = 18;
  localparam int unsigned ThrW   = 32;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PEND  = 2'd1,
    KIND_STEER = 2'd2,
    KIND_SPEED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_OK   = 2'd1,
    REPLY_NK   = 2'd2
  } reply_e;

  typedef struct packed {
    logic              valid;
    reply_e            reply;
    logic [SteerW-1:0] steering;
    logic [ThrW-1:0]   throttle;
  } result_t;

  // Weight of fractional digit k+1 in units of 2^-16, truncated.
  function automatic logic [12:0] frac_weight(input logic [2:0] idx);
    logic [12:0] w;
    unique case (idx)
      3'd0:    w = 13'd6553;
      3'd1:    w = 13'd655;
      3'd2:    w = 13'd65;
      3'd3:    w = 13'd6;
      default: w = 13'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== src/ascp_parser.sv =====
// Line state and setpoint registers of the command parser: each accepted byte
// updates the registered state. Depends on ascp_pkg.
module ascp_parser #(
  parameter int unsigned FRAC_DIGITS = 5,
  parameter int unsigned INT_BITS    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        byte_i,
  output ascp_pkg::result_t result_o
);
  import ascp_pkg::*;

  localparam int unsigned MagW = INT_BITS + 17;

  logic [1:0]          pos_q, pos_d;
  kind_e               kind_q, kind_d;
  logic                ended_q, ended_d;
  logic                neg_q, neg_d;
  logic                point_q, point_d;
  logic [INT_BITS-1:0] int_q, int_d;
  logic [16:0]         frac_q, frac_d;
  logic [2:0]          fcnt_q, fcnt_d;
  logic [SteerW-1:0]   steer_q, steer_d;
  logic [ThrW-1:0]     thr_q, thr_d;

  logic [INT_BITS+3:0] int_next;
  logic [3:0]          digit;
  logic                is_digit;
  logic [MagW-1:0]     mag;
  logic [63:0]         mag64;
  logic [ThrW-1:0]     value;
  reply_e              reply;

  assign digit    = 4'(byte_i - ChZero);
  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign int_next = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) + (INT_BITS + 4)'(digit);

  assign mag   = {1'b0, int_q, 16'b0} + MagW'(frac_q);
  assign mag64 = 64'(mag);

  always_comb begin
    if (!neg_q) begin
      value = (mag64 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag64[31:0];
    end else begin
      value = (mag64 > 64'h8000_0000) ? 32'h8000_0000 : 32'(~mag64[31:0] + 32'd1);
    end
  end

  always_comb begin
    pos_d   = pos_q;
    kind_d  = kind_q;
    ended_d = ended_q;
    neg_d   = neg_q;
    point_d = point_q;
    int_d   = int_q;
    frac_d  = frac_q;
    fcnt_d  = fcnt_q;
    steer_d = steer_q;
    thr_d   = thr_q;
    reply   = REPLY_NONE;
    if (take_i && byte_i != ChNewline) begin
      unique case (pos_q)
        PosFirst: begin
          kind_d = (byte_i == ChS) ? KIND_PEND : KIND_NONE;
          pos_d  = PosSecond;
        end
        PosSecond: begin
          if (kind_q == KIND_PEND) begin
            kind_d = (byte_i == ChS) ? KIND_STEER :
                     (byte_i == ChR) ? KIND_SPEED : KIND_NONE;
          end
          pos_d = PosColon;
        end
        PosColon: begin
          if ((kind_q == KIND_STEER || kind_q == KIND_SPEED) && byte_i != ChColon) begin
            kind_d = KIND_PEND;
          end
          pos_d = PosNumber;
        end
        default: begin
          if (!ended_q) begin
            priority if (byte_i == ChMinus) begin
              neg_d = 1'b1;
            end else if (byte_i == ChPoint) begin
              point_d = 1'b1;
            end else if (is_digit) begin
              if (!point_q) begin
                int_d = (int_next[INT_BITS+3:INT_BITS] != 4'd0) ? {INT_BITS{1'b1}}
                                                                 : int_next[INT_BITS-1:0];
              end else if (fcnt_q < 3'(FRAC_DIGITS)) begin
                frac_d = frac_q + 17'(digit) * 17'(frac_weight(fcnt_q));
                fcnt_d = fcnt_q + 3'd1;
              end
            end else begin
              ended_d = 1'b1;
            end
          end
        end
      endcase
    end else if (take_i) begin
      if (pos_q == PosColon) begin
        if (kind_q == KIND_STEER || kind_q == KIND_SPEED) begin
          reply = REPLY_NK;
        end
      end else if (pos_q == PosNumber) begin
        unique case (kind_q)
          KIND_PEND: reply = REPLY_NK;
          KIND_STEER: begin
            if (mag64 <= 64'd65536) begin
              steer_d = value[SteerW-1:0];
              reply   = REPLY_OK;
            end else begin
              reply = REPLY_NK;
            end
          end
          KIND_SPEED: begin
            thr_d = value;
            reply = REPLY_OK;
          end
          default: reply = REPLY_NONE;
        endcase
      end
      pos_d   = PosFirst;
      kind_d  = KIND_NONE;
      ended_d = 1'b0;
      neg_d   = 1'b0;
      point_d = 1'b0;
      int_d   = '0;
      frac_d  = '0;
      fcnt_d  = '0;
    end
  end

  assign result_o.valid    = take_i && (byte_i == ChNewline);
  assign result_o.reply    = reply;
  assign result_o.steering = steer_d;
  assign result_o.throttle = thr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosFirst;
      kind_q  <= KIND_NONE;
      ended_q <= 1'b0;
      neg_q   <= 1'b0;
      point_q <= 1'b0;
      int_q   <= '0;
      frac_q  <= '0;
      fcnt_q  <= '0;
      steer_q <= '0;
      thr_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      kind_q  <= kind_d;
      ended_q <= ended_d;
      neg_q   <= neg_d;
      point_q <= point_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      fcnt_q  <= fcnt_d;
      steer_q <= steer_d;
      thr_q   <= thr_d;
    end
  end

endmodule

// ===== src/ascii_setpoint_command_parser.sv =====
// Top level of the ASCII setpoint command parser: byte stream in, one reply
// item per newline out through an output register and a skid stage.
// Depends on ascp_pkg and ascp_parser.
//
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] rx_byte
// m_axis    out        tdata[1:0] reply, [19:2] steering_value, [51:20] throttle_value
//
// One byte is taken per cycle unless input stalls; parser state updates in the same
// cycle and a newline's reply is registered in the output or else the skid stage.
// The skid stage holds a second reply, so bytes keep flowing while one reply
// waits; input stalls only while both output slots are full.
// Reset clears the line state, both setpoints and the output valid flags.
module ascii_setpoint_command_parser #(
  parameter int unsigned FRAC_DIGITS = 5,
  parameter int unsigned INT_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // reply, steering_value, throttle_value, zero fill
);
  import ascp_pkg::*;

  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    take;
  logic    out_fire;

  assign s_axis_tready = !skid_valid_q;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  ascp_parser #(
    .FRAC_DIGITS(FRAC_DIGITS),
    .INT_BITS   (INT_BITS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .byte_i  (s_axis_tdata),
    .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_valid_q <= res.valid;
    end else if (res.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_fire) begin
      out_q <= res;
    end else if (res.valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.throttle, out_q.steering, out_q.reply};

endmodule

// ===== bench/ascii_setpoint_command_parser_checker.sv =====
`timescale 1ns / 100ps
// Checker for the ASCII setpoint command parser: it watches both streams,
// predicts each newline's reply item and compares it field by field.
// Depends on ascp_pkg.
module ascii_setpoint_command_parser_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [55:0] m_axis_tdata_i,   // reply, steering_value, throttle_value, zero fill
  output int          fail_count_o,
  output int          pending_o,
  output int          ok_count_o,
  output int          nk_count_o,
  output int          silent_count_o
);
  import ascp_pkg::*;

  localparam int unsigned FracDigits = 5;
  localparam int unsigned IntBits    = 16;
  localparam longint unsigned IntMax = (64'd1 << IntBits) - 1;

  typedef struct {
    reply_e            reply;
    logic [SteerW-1:0] steering;
    logic [ThrW-1:0]   throttle;
  } setpoint_reply_t;

  setpoint_reply_t   expected_replies[$];
  logic [1:0]        header_pos;
  kind_e             line_kind;
  bit                number_done;
  bit                minus_seen;
  bit                point_seen;
  longint unsigned   whole_part;
  int unsigned       frac_part;
  int unsigned       frac_taken;
  logic [SteerW-1:0] steering_sp;
  logic [ThrW-1:0]   throttle_sp;

  task automatic start_line();
    header_pos  = PosFirst;
    line_kind   = KIND_NONE;
    number_done = 1'b0;
    minus_seen  = 1'b0;
    point_seen  = 1'b0;
    whole_part  = 0;
    frac_part   = 0;
    frac_taken  = 0;
  endtask

  // Signed Q16.16 value of the line so far, clamped to 32 bits.
  function automatic longint signed line_setpoint();
    longint signed v;
    v = longint'((whole_part << 16) + frac_part);
    if (minus_seen) begin
      v = -v;
    end
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
    end
    return v;
  endfunction

  task automatic take_number_char(input logic [7:0] ch);
    int unsigned digit;
    if (number_done) begin
      return;
    end
    if (ch == ChMinus) begin
      minus_seen = 1'b1;
    end else if (ch == ChPoint) begin
      point_seen = 1'b1;
    end else if (ch >= ChZero && ch <= ChNine) begin
      digit = ch - ChZero;
      if (!point_seen) begin
        whole_part = whole_part * 10 + digit;
        if (whole_part > IntMax) begin
          whole_part = IntMax;
        end
      end else if (frac_taken < FracDigits) begin
        frac_part  = frac_part + digit * (65536 / (10 ** (frac_taken + 1)));
        frac_taken = frac_taken + 1;
      end
    end else begin
      number_done = 1'b1;
    end
  endtask

  task automatic take_byte(input logic [7:0] ch);
    setpoint_reply_t r;
    longint signed   v;
    if (ch != ChNewline) begin
      case (header_pos)
        PosFirst: begin
          line_kind  = (ch == ChS) ? KIND_PEND : KIND_NONE;
          header_pos = PosSecond;
        end
        PosSecond: begin
          if (line_kind == KIND_PEND) begin
            line_kind = (ch == ChS) ? KIND_STEER : (ch == ChR) ? KIND_SPEED : KIND_NONE;
          end
          header_pos = PosColon;
        end
        PosColon: begin
          if ((line_kind == KIND_STEER || line_kind == KIND_SPEED) && ch != ChColon) begin
            line_kind = KIND_PEND;
          end
          header_pos = PosNumber;
        end
        default: begin
          take_number_char(ch);
        end
      endcase
      return;
    end
    r.reply = REPLY_NONE;
    if (header_pos == PosColon) begin
      if (line_kind == KIND_STEER || line_kind == KIND_SPEED) begin
        r.reply = REPLY_NK;
      end
    end else if (header_pos == PosNumber) begin
      v = line_setpoint();
      if (line_kind == KIND_PEND) begin
        r.reply = REPLY_NK;
      end else if (line_kind == KIND_STEER) begin
        if (v >= -64'sd65536 && v <= 64'sd65536) begin
          steering_sp = v[SteerW-1:0];
          r.reply     = REPLY_OK;
        end else begin
          r.reply = REPLY_NK;
        end
      end else if (line_kind == KIND_SPEED) begin
        throttle_sp = v[ThrW-1:0];
        r.reply     = REPLY_OK;
      end
    end
    r.steering = steering_sp;
    r.throttle = throttle_sp;
    expected_replies.push_back(r);
    start_line();
  endtask

  task automatic check_reply(input logic [55:0] data);
    setpoint_reply_t want;
    if (expected_replies.size() == 0) begin
      $error("reply item 0x%h arrived with none expected", data);
      fail_count_o++;
      return;
    end
    want = expected_replies.pop_front();
    if (data[1:0] !== want.reply) begin
      $error("reply: expected %0d, got %0d", want.reply, data[1:0]);
      fail_count_o++;
    end
    if (data[19:2] !== want.steering) begin
      $error("steering_value: expected %0d, got %0d",
             $signed(want.steering), $signed(data[19:2]));
      fail_count_o++;
    end
    if (data[51:20] !== want.throttle) begin
      $error("throttle_value: expected %0d, got %0d",
             $signed(want.throttle), $signed(data[51:20]));
      fail_count_o++;
    end
    case (want.reply)
      REPLY_OK: ok_count_o++;
      REPLY_NK: nk_count_o++;
      default:  silent_count_o++;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_replies.delete();
      start_line();
      steering_sp = '0;
      throttle_sp = '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        take_byte(s_axis_tdata_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_reply(m_axis_tdata_i);
      end
    end
    pending_o = expected_replies.size();
  end

endmodule

// ===== bench/ascii_setpoint_command_parser_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the ASCII setpoint command parser: drives command lines
// with random gaps and stalls and gives the verdict.
// Depends on ascp_pkg, the parser RTL and ascii_setpoint_command_parser_checker.
module ascii_setpoint_command_parser_tb;
  import ascp_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int ByteTarget = 800;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;

  int         fail_count;
  int         pending;
  int         ok_count;
  int         nk_count;
  int         silent_count;
  int         bytes_sent;
  int         newlines_sent;
  int         cycle_count;
  bit         no_idle;
  logic [7:0] line_buf[$];

  ascii_setpoint_command_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ascii_setpoint_command_parser_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .ok_count_o      (ok_count),
    .nk_count_o      (nk_count),
    .silent_count_o  (silent_count)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (b == ChNewline) begin
      newlines_sent++;
    end
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] any_but_newline();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ChNewline);
    return b;
  endfunction

  // Mostly well-formed setpoint lines, else broken headers or raw noise.
  task automatic random_line();
    int         pick;
    int         n;
    int         i;
    bit         steer;
    bit         near_unit;
    logic [7:0] b;
    line_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      steer     = $urandom_range(0, 1);
      near_unit = steer && ($urandom_range(0, 3) != 0);
      line_buf.push_back(ChS);
      line_buf.push_back(steer ? ChS : ChR);
      line_buf.push_back(ChColon);
      if ($urandom_range(0, 9) < 4) begin
        line_buf.push_back(ChMinus);
      end
      if (near_unit) begin
        n = $urandom_range(0, 1);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 2);
      end
      for (i = 0; i < n; i++) begin
        line_buf.push_back(8'(ChZero + (near_unit ? $urandom_range(0, 1) : $urandom_range(0, 9))));
      end
      if ($urandom_range(0, 9) < 6) begin
        line_buf.push_back(ChPoint);
        n = $urandom_range(0, 7);
        for (i = 0; i < n; i++) begin
          line_buf.push_back(8'(ChZero + $urandom_range(0, 9)));
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        line_buf.push_back($urandom_range(0, 1) ? ChMinus : ChPoint);
        line_buf.push_back(8'(ChZero + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 9) < 2) begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          line_buf.push_back(any_but_newline());
        end
      end
      line_buf.push_back(ChNewline);
    end else if (pick < 85) begin
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(0, 4))
          0:       b = ChS;
          1:       b = ChR;
          2:       b = ChColon;
          3:       b = 8'(ChZero + $urandom_range(0, 9));
          default: b = any_but_newline();
        endcase
        line_buf.push_back(b);
      end
      line_buf.push_back(ChNewline);
    end else begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) begin
        line_buf.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 1) begin
        line_buf.push_back(ChNewline);
      end
    end
    foreach (line_buf[k]) begin
      send_byte(line_buf[k]);
    end
  endtask

  initial begin : reply_sink
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    no_idle       = 1'b0;
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Short lines, broken and unknown headers, empty number, saturation,
    // number end, steering limits.
    send_text("\n");
    send_text("S\n");
    send_text("SR\n");
    send_text("SS*\n");
    send_byte(8'h00);
    send_text("B:\n");
    send_text("SS:\n");
    send_text("SR:-99999.999999");
    send_byte(8'hFF);
    send_text("5\n");
    send_text("SS:2\n");
    send_text("SS:-1\n");

    while (bytes_sent < ByteTarget) begin
      no_idle = ($urandom_range(0, 4) == 0);
      random_line();
    end
    no_idle = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Sent %0d bytes with %0d newlines under random gaps and stalls.",
             bytes_sent, newlines_sent);
    $display("Checked replies: %0d OK, %0d NK, %0d without reply.",
             ok_count, nk_count, silent_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ascp_pkg.sv
src/ascp_parser.sv
src/ascii_setpoint_command_parser.sv
bench/ascii_setpoint_command_parser_checker.sv
bench/ascii_setpoint_command_parser_tb.sv
